// ===== design/indexed_position_pid_with_homing_defines.svh =====
// ----------------------------------------------------------------------------
// indexed position pid: assertion macros
// shared property wrappers, sampled on clk_i with reset held off
// ----------------------------------------------------------------------------
`ifndef INDEXED_POSITION_PID_WITH_HOMING_DEFINES_SVH
`define INDEXED_POSITION_PID_WITH_HOMING_DEFINES_SVH

// same-cycle implication
`define IPPID_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IPPID_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ippid_pkg.sv =====
// ----------------------------------------------------------------------------
// indexed position pid package
// codes, reset values and saturating fixed-point helpers
// ----------------------------------------------------------------------------
package ippid_pkg;

  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned NUM_STAGES = 7;

  typedef enum logic [2:0] {
    REG_KP_GAIN   = 3'd0,
    REG_KI_PERIOD = 3'd1,
    REG_KD_PERIOD = 3'd2,
    REG_PWM_PER   = 3'd3,
    REG_SPACING   = 3'd4,
    REG_EDGE      = 3'd5,
    REG_STALL_MS  = 3'd6,
    REG_DEADBAND  = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_START = 2'd1,
    MODE_STOP  = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'b001,
    PH_HOMING  = 3'b010,
    PH_RUNNING = 3'b100
  } phase_e;

  localparam logic [1:0] PHASE_CODE_IDLE    = 2'd0;
  localparam logic [1:0] PHASE_CODE_HOMING  = 2'd1;
  localparam logic [1:0] PHASE_CODE_RUNNING = 2'd2;

  localparam logic [2:0] REQ_FAR_RIGHT = 3'd0;
  localparam logic [2:0] REQ_RIGHT     = 3'd1;
  localparam logic [2:0] REQ_MIDDLE    = 3'd2;
  localparam logic [2:0] REQ_LEFT      = 3'd3;
  localparam logic [2:0] REQ_FAR_LEFT  = 3'd4;

  localparam logic [31:0] KP_RESET       = 32'd3276800;
  localparam logic [31:0] KI_RESET       = 32'd2621;
  localparam logic [31:0] KD_RESET       = 32'd4587520;
  localparam logic [15:0] PWM_PER_RESET  = 16'd1000;
  localparam logic [12:0] SPACING_RESET  = 13'd810;
  localparam logic [12:0] EDGE_RESET     = 13'd1980;
  localparam logic [15:0] STALL_MS_RESET = 16'd70;
  localparam logic [15:0] DEADBAND_RESET = 16'd200;
  localparam logic [2:0]  LAST_REQ_RESET = 3'd7;
  localparam logic [31:0] STALL_T_RESET  = 32'd65535;

  localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S64_MIN = {1'b1, 63'b0};

  typedef struct packed {
    logic       preset;
    logic [1:0] phase;
  } side_t;

  function automatic logic [1:0] phase_code(phase_e p);
    logic [1:0] c;
    case (p)
      PH_HOMING:  c = PHASE_CODE_HOMING;
      PH_RUNNING: c = PHASE_CODE_RUNNING;
      default:    c = PHASE_CODE_IDLE;
    endcase
    return c;
  endfunction

  // saturating add on the signed 64-bit range
  function automatic logic signed [63:0] sat_add(logic signed [63:0] a,
                                                 logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? S64_MIN : S64_MAX;
    end
    return s[63:0];
  endfunction

  // gain times low 18 bits of the operand, unsigned
  function automatic logic [49:0] pp_lo(logic [31:0] g, logic [34:0] e);
    logic [49:0] r;
    r = {18'b0, g} * {32'b0, e[17:0]};
    return r;
  endfunction

  // gain times signed upper 17 bits of the operand
  function automatic logic signed [49:0] pp_hi(logic [31:0] g, logic [34:0] e);
    logic signed [49:0] r;
    r = $signed({18'b0, g}) * $signed({{33{e[34]}}, e[34:18]});
    return r;
  endfunction

  // join partial products and clamp the exact product to 64 bits
  function automatic logic signed [63:0] join_clamp(logic signed [49:0] hi,
                                                    logic [49:0] lo);
    logic signed [67:0] s;
    s = $signed({hi, 18'b0}) + $signed({18'b0, lo});
    if ((&s[67:63]) || !(|s[67:63])) begin
      return s[63:0];
    end
    return s[67] ? S64_MIN : S64_MAX;
  endfunction

endpackage

// ===== design/indexed_position_pid_with_homing.sv =====
// ----------------------------------------------------------------------------
// indexed position pid with homing
// homing ramp, stall detect and five-position pid with pwm output
// ----------------------------------------------------------------------------
//
// channel   dir  handshake            payload
// s_*       in   s_tvalid/s_tready    tuser: mode, tdata: now, encoder, request
// m_*       out  m_tvalid/m_tready    tdata: dir_a, dir_b, duty, preset, phase
// cfg_*     in   cfg_we_i             cfg_idx_i selects register, cfg_data_i value
//
// one word accepted per cycle unless a stalled output backs the pipe up; a tick
// that drives the motor reaches the output register through the split 32x35 gain
// multipliers and the saturating add chain behind them
// start, stop, idle ticks and mode three settle in the acceptance cycle
// the integral accumulator and the previous error are the only loops: one
// saturating 64-bit add and one 35-bit subtract a word
// reset clears phase, ramp, stall and pid state and loads the default gains
// a stalled output backs the pipe up stage by stage; bubbles keep s_tready high
//
`include "indexed_position_pid_with_homing_defines.svh"

module indexed_position_pid_with_homing
  import ippid_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_tvalid_i,
  output logic                  s_tready_o,
  input  logic [55:0]           s_tdata_i,   // now_ms, encoder_count, position_request, pad
  input  logic [1:0]            s_tuser_i,   // mode
  output logic                  m_tvalid_o,
  input  logic                  m_tready_i,
  output logic [23:0]           m_tdata_o,   // dir_a, dir_b, duty, preset_encoder, phase, pad
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // configuration registers
  logic [31:0] kp_q, ki_q, kd_q;
  logic [15:0] period_q, stall_ms_q, deadband_q;
  logic [12:0] spacing_q, edge_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q       <= KP_RESET;
      ki_q       <= KI_RESET;
      kd_q       <= KD_RESET;
      period_q   <= PWM_PER_RESET;
      spacing_q  <= SPACING_RESET;
      edge_q     <= EDGE_RESET;
      stall_ms_q <= STALL_MS_RESET;
      deadband_q <= DEADBAND_RESET;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_KP_GAIN:   kp_q       <= cfg_data_i;
        REG_KI_PERIOD: ki_q       <= cfg_data_i;
        REG_KD_PERIOD: kd_q       <= cfg_data_i;
        REG_PWM_PER:   period_q   <= cfg_data_i[15:0];
        REG_SPACING:   spacing_q  <= cfg_data_i[12:0];
        REG_EDGE:      edge_q     <= cfg_data_i[12:0];
        REG_STALL_MS:  stall_ms_q <= cfg_data_i[15:0];
        REG_DEADBAND:  deadband_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // input word fields
  logic [31:0]        in_now;
  logic signed [15:0] in_enc;
  logic [2:0]         in_req;
  mode_e              in_mode;
  logic               s_fire;

  assign in_now  = s_tdata_i[31:0];
  assign in_enc  = $signed(s_tdata_i[47:32]);
  assign in_req  = s_tdata_i[50:48];
  assign in_mode = mode_e'(s_tuser_i);

  // handshake chain: stage k may load when it is empty or its word moves on
  logic [NUM_STAGES:1]   v_q;
  logic [NUM_STAGES+1:1] en;
  logic                  out_valid_q;

  always_comb begin
    en[NUM_STAGES+1] = !out_valid_q || m_tready_i;
    for (int k = NUM_STAGES; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign s_tready_o = en[1];
  assign s_fire     = s_tvalid_i && s_tready_o;

  // sequencing state
  phase_e             phase_q, phase_d;
  logic [31:0]        start_q, start_d;
  logic signed [32:0] target_q, target_d;
  logic [2:0]         last_req_q, last_req_d;
  logic [15:0]        stall_enc_q, stall_enc_d;
  logic [31:0]        stall_time_q, stall_time_d;
  logic signed [33:0] prev_err_q;
  logic signed [63:0] integral_q;

  logic signed [32:0] req_target;
  logic signed [32:0] sp33;
  logic [31:0]        stall_limit;
  logic               emit_c, preset_c;
  logic signed [15:0] measured_c;

  assign sp33        = $signed({20'b0, spacing_q});
  assign stall_limit = stall_time_q + {16'b0, stall_ms_q};

  // indexed position targets
  always_comb begin
    case (in_req)
      REQ_FAR_RIGHT: req_target = sp33 <<< 1;
      REQ_RIGHT:     req_target = sp33;
      REQ_MIDDLE:    req_target = '0;
      REQ_LEFT:      req_target = -sp33;
      REQ_FAR_LEFT:  req_target = -(sp33 <<< 1);
      default:       req_target = '0;
    endcase
  end

  always_comb begin
    phase_d      = phase_q;
    start_d      = start_q;
    target_d     = target_q;
    last_req_d   = last_req_q;
    stall_enc_d  = stall_enc_q;
    stall_time_d = stall_time_q;
    emit_c       = 1'b0;
    preset_c     = 1'b0;
    measured_c   = in_enc;
    case (in_mode)
      MODE_START: begin
        phase_d = PH_HOMING;
        start_d = in_now;
      end
      MODE_STOP: phase_d = PH_IDLE;
      MODE_TICK: begin
        case (phase_q)
          PH_HOMING: begin
            emit_c   = 1'b1;
            // ramp: one count per ms since start
            target_d = $signed({1'b0, in_now - start_q});
            if (s_tdata_i[47:32] != stall_enc_q) begin
              stall_enc_d  = s_tdata_i[47:32];
              stall_time_d = in_now;
            end else if (stall_limit < in_now) begin
              // edge reached: preset the encoder and measure the preset value
              preset_c   = 1'b1;
              phase_d    = PH_RUNNING;
              measured_c = $signed({3'b0, edge_q});
            end
          end
          PH_RUNNING: begin
            emit_c = 1'b1;
            if (in_req != last_req_q) begin
              target_d   = req_target;
              last_req_d = in_req;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // pipeline payload
  side_t              side_q [1:NUM_STAGES];
  logic signed [32:0] tgt1_q;
  logic signed [15:0] meas1_q;
  logic signed [33:0] err2_q;
  logic signed [34:0] derr2_q;
  logic [49:0]        kp_lo3_q, ki_lo3_q, kd_lo3_q;
  logic signed [49:0] kp_hi3_q, ki_hi3_q, kd_hi3_q;
  logic               gate3_q, gate4_q;
  logic signed [63:0] pt4_q, it4_q, dt4_q;
  logic signed [63:0] pt5_q, dt5_q, ival5_q;
  logic signed [63:0] c6_q, dt6_q;
  logic signed [63:0] ctrl7_q;
  logic               out_dir_a_q, out_dir_b_q, out_preset_q;
  logic [13:0]        out_duty_q;
  logic [1:0]         out_phase_q;

  // error and error change
  logic signed [33:0] err_c;
  logic signed [34:0] derr_c;
  logic signed [34:0] err35;
  assign err_c  = {tgt1_q[32], tgt1_q} - {{18{meas1_q[15]}}, meas1_q};
  assign derr_c = {err_c[33], err_c} - {prev_err_q[33], prev_err_q};
  assign err35  = {err2_q[33], err2_q};

  // integral gate: 10*|err| > spacing, tested on the signed product
  logic signed [37:0] err38, e10, sp38;
  logic               gate_c;
  assign err38  = {{4{err2_q[33]}}, err2_q};
  assign e10    = (err38 <<< 3) + (err38 <<< 1);
  assign sp38   = $signed({25'b0, spacing_q});
  assign gate_c = (e10 > sp38) || (e10 < -sp38);

  logic signed [63:0] integral_c;
  assign integral_c = gate4_q ? sat_add(integral_q, it4_q) : integral_q;

  // output shaping
  logic signed [63:0] th, neg_th;
  logic [63:0]        mag;
  logic [47:0]        whole;
  logic [13:0]        cap;
  assign th     = $signed({32'b0, deadband_q, 16'b0});
  assign neg_th = -th;
  assign mag    = ctrl7_q[63] ? (~ctrl7_q + 64'd1) : ctrl7_q;
  assign whole  = mag[63:16];
  assign cap    = period_q[15:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      start_q      <= '0;
      target_q     <= '0;
      last_req_q   <= LAST_REQ_RESET;
      stall_enc_q  <= '0;
      stall_time_q <= STALL_T_RESET;
      prev_err_q   <= '0;
      integral_q   <= '0;
      v_q          <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (s_fire) begin
        phase_q      <= phase_d;
        start_q      <= start_d;
        target_q     <= target_d;
        last_req_q   <= last_req_d;
        stall_enc_q  <= stall_enc_d;
        stall_time_q <= stall_time_d;
      end
      if (en[2] && v_q[1]) begin
        prev_err_q <= err_c;
      end
      if (en[5] && v_q[4]) begin
        integral_q <= integral_c;
      end
      if (en[1]) begin
        v_q[1] <= s_fire && emit_c;
      end
      for (int k = 2; k <= NUM_STAGES; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
      if (en[NUM_STAGES+1]) begin
        out_valid_q <= v_q[NUM_STAGES];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      tgt1_q    <= target_d;
      meas1_q   <= measured_c;
      side_q[1] <= '{preset: preset_c, phase: phase_code(phase_d)};
    end
    for (int k = 2; k <= NUM_STAGES; k++) begin
      if (en[k]) begin
        side_q[k] <= side_q[k-1];
      end
    end
    if (en[2]) begin
      err2_q  <= err_c;
      derr2_q <= derr_c;
    end
    if (en[3]) begin
      kp_lo3_q <= pp_lo(kp_q, err35);
      kp_hi3_q <= pp_hi(kp_q, err35);
      ki_lo3_q <= pp_lo(ki_q, err35);
      ki_hi3_q <= pp_hi(ki_q, err35);
      kd_lo3_q <= pp_lo(kd_q, derr2_q);
      kd_hi3_q <= pp_hi(kd_q, derr2_q);
      gate3_q  <= gate_c;
    end
    if (en[4]) begin
      pt4_q   <= join_clamp(kp_hi3_q, kp_lo3_q);
      it4_q   <= join_clamp(ki_hi3_q, ki_lo3_q);
      dt4_q   <= join_clamp(kd_hi3_q, kd_lo3_q);
      gate4_q <= gate3_q;
    end
    if (en[5]) begin
      pt5_q   <= pt4_q;
      dt5_q   <= dt4_q;
      ival5_q <= integral_c;
    end
    if (en[6]) begin
      c6_q  <= sat_add(pt5_q, ival5_q);
      dt6_q <= dt5_q;
    end
    if (en[7]) begin
      ctrl7_q <= sat_add(c6_q, dt6_q);
    end
    if (en[NUM_STAGES+1]) begin
      out_dir_a_q  <= ctrl7_q > th;
      out_dir_b_q  <= ctrl7_q < neg_th;
      out_duty_q   <= (whole > {34'b0, cap}) ? cap : whole[13:0];
      out_preset_q <= side_q[NUM_STAGES].preset;
      out_phase_q  <= side_q[NUM_STAGES].phase;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {5'b0, out_phase_q, out_preset_q, out_duty_q, out_dir_b_q, out_dir_a_q};

  // checks
  `IPPID_ASSERT(a_dir_exclusive, out_valid_q, !(out_dir_a_q && out_dir_b_q), "both direction pins set")
  `IPPID_ASSERT(a_duty_capped, out_valid_q, out_duty_q <= period_q[15:2], "duty above quarter period")
  `IPPID_ASSERT(a_preset_runs, out_valid_q && out_preset_q, out_phase_q == PHASE_CODE_RUNNING, "preset outside running")
  `IPPID_ASSERT_NEXT(a_integral_hold, !(en[5] && v_q[4]), $stable(integral_q), "integral moved without a word")

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// indexed position pid with homing: self-checking regression bench
// streams start, stop and tick words through the block under random sender
// bursts and receiver stalls, predicts every motor word with a bit-exact
// saturating q16.16 controller model and compares field by field
// ----------------------------------------------------------------------------
module tb;
  import ippid_pkg::*;

  // unused mode code and the three "no position" request codes
  localparam logic [1:0] MODE_UNUSED  = 2'd3;
  localparam logic [2:0] REQ_SPARE_LO = 3'd5;
  localparam logic [2:0] REQ_SPARE_MD = 3'd6;
  localparam logic [2:0] REQ_SPARE_HI = 3'd7;

  localparam int SEGMENTS       = 11;
  localparam int SEG_ITEMS      = 92;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PIPE_SETTLE    = 12;   // covers the pipe plus margin
  localparam int MAX_PRINTED    = 40;

  localparam logic signed [127:0] WIDE_TOP = {65'b0, {63{1'b1}}};
  localparam logic signed [127:0] WIDE_BOT = {{65{1'b1}}, 63'b0};

  // command word, now_ms in the low bits as on s_tdata_i
  typedef struct packed {
    logic [1:0]  mode;
    logic [2:0]  req;
    logic [15:0] enc;
    logic [31:0] now;
  } cmd_word_t;

  // motor word, dir_a in bit 0 as on m_tdata_o
  typedef struct packed {
    logic [1:0]  phase;
    logic        preset;
    logic [13:0] duty;
    logic        dir_b;
    logic        dir_a;
  } motor_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid_i = 1'b0;
  logic        s_tready_o;
  logic [55:0] s_tdata_i = '0;   // now_ms, encoder_count, position_request, pad
  logic [1:0]  s_tuser_i = '0;   // mode
  logic        m_tvalid_o;
  logic        m_tready_i = 1'b0;
  logic [23:0] m_tdata_o;        // dir_a, dir_b, duty, preset_encoder, phase, pad
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  indexed_position_pid_with_homing uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // controller model: gains, limits and loop state as the block holds them
  // --------------------------------------------------------------------------
  logic [31:0] kp = KP_RESET;
  logic [31:0] ki = KI_RESET;
  logic [31:0] kd = KD_RESET;
  logic [15:0] pwm_per = PWM_PER_RESET;
  logic [12:0] spacing = SPACING_RESET;
  logic [12:0] edge_at = EDGE_RESET;
  logic [15:0] stall_len = STALL_MS_RESET;
  logic [15:0] deadband = DEADBAND_RESET;

  logic [1:0]  ctl_phase = PHASE_CODE_IDLE;
  logic [31:0] ramp_start = '0;
  longint      set_point = 0;
  logic [2:0]  held_request = LAST_REQ_RESET;
  logic [15:0] still_count = '0;
  logic [31:0] still_since = STALL_T_RESET;
  longint      last_error = 0;
  longint      err_sum = 0;

  function automatic longint clamp64(logic signed [127:0] v);
    if (v > WIDE_TOP) return longint'(WIDE_TOP[63:0]);
    if (v < WIDE_BOT) return longint'(WIDE_BOT[63:0]);
    return longint'(v[63:0]);
  endfunction

  function automatic longint sum_sat(longint a, longint b);
    logic signed [127:0] wa, wb;
    wa = 128'(a);
    wb = 128'(b);
    return clamp64(wa + wb);
  endfunction

  // unsigned q16.16 gain times signed count, exact then clamped
  function automatic longint gain_mul(logic [31:0] g, longint e);
    logic signed [127:0] wg, we;
    wg = {96'b0, g};
    we = 128'(e);
    return clamp64(wg * we);
  endfunction

  function automatic longint index_target(logic [2:0] r);
    longint s;
    s = longint'({51'b0, spacing});
    case (r)
      REQ_FAR_RIGHT: return 2 * s;
      REQ_RIGHT:     return s;
      REQ_LEFT:      return -s;
      REQ_FAR_LEFT:  return -2 * s;
      default:       return 0;
    endcase
  endfunction

  // advances the controller by one command; returns 1 when a motor word is due
  function automatic bit step_controller(input cmd_word_t c, output motor_word_t r);
    longint      meas, err, ctrl, th;
    logic [63:0] aerr, mag, whole, cap;
    logic [31:0] deadline;
    logic        preset;
    r = '0;
    preset = 1'b0;
    meas = longint'($signed(c.enc));
    if (c.mode == MODE_START) begin
      ctl_phase = PHASE_CODE_HOMING;
      ramp_start = c.now;
      return 1'b0;
    end
    if (c.mode == MODE_STOP) begin
      ctl_phase = PHASE_CODE_IDLE;
      return 1'b0;
    end
    if (c.mode != MODE_TICK || ctl_phase == PHASE_CODE_IDLE) return 1'b0;

    if (ctl_phase == PHASE_CODE_HOMING) begin
      // ramp one count per ms, unsigned modulo 2^32
      set_point = longint'({32'b0, c.now - ramp_start});
      deadline = still_since + {16'b0, stall_len};
      if (c.enc != still_count) begin
        still_count = c.enc;
        still_since = c.now;
      end else if (deadline < c.now) begin
        // edge found: measure the preset value on this tick
        preset = 1'b1;
        ctl_phase = PHASE_CODE_RUNNING;
        meas = longint'({51'b0, edge_at});
      end
    end else if (c.req != held_request) begin
      set_point = index_target(c.req);
      held_request = c.req;
    end

    err = set_point - meas;
    aerr = (err < 0) ? -err : err;
    // integral only accumulates outside a tenth of the spacing
    if (aerr * 64'd10 > {51'b0, spacing}) err_sum = sum_sat(err_sum, gain_mul(ki, err));
    ctrl = sum_sat(gain_mul(kp, err), err_sum);
    ctrl = sum_sat(ctrl, gain_mul(kd, err - last_error));
    last_error = err;

    th = longint'({16'b0, deadband, 16'b0});
    mag = (ctrl < 0) ? -ctrl : ctrl;
    whole = mag >> 16;
    cap = {50'b0, pwm_per[15:2]};
    r.dir_a = (ctrl > th);
    r.dir_b = (ctrl < -th);
    r.duty = (whole > cap) ? cap[13:0] : whole[13:0];
    r.preset = preset;
    r.phase = ctl_phase;
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // shared bench state
  // --------------------------------------------------------------------------
  cmd_word_t   pending_words[$];
  motor_word_t motor_expected[$];
  cmd_word_t   word_on_bus;
  bit          bus_busy = 1'b0;    // a word sits on s_* waiting for tready
  bit          steady = 1'b0;      // no sender gaps and no receiver stalls
  int          fail_count = 0;
  int          words_checked = 0;
  int          quiet_cycles = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          stall_left = 0;
  logic [31:0] clock_ms = '0;
  logic [15:0] shaft = '0;

  task automatic report(string what);
    fail_count++;
    if (fail_count <= MAX_PRINTED) $display("mismatch: %s", what);
  endtask

  // --------------------------------------------------------------------------
  // driver: sender bursts with gaps, receiver stalls on its own pattern
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!bus_busy) begin
        if (gap_left != 0) begin
          gap_left--;
          s_tvalid_i <= 1'b0;
        end else if (pending_words.size() != 0) begin
          word_on_bus = pending_words.pop_front();
          bus_busy = 1'b1;
          s_tvalid_i <= 1'b1;
          s_tdata_i <= {5'b0, word_on_bus.req, word_on_bus.enc, word_on_bus.now};
          s_tuser_i <= word_on_bus.mode;
          if (burst_left != 0) begin
            burst_left--;
          end else if (steady) begin
            gap_left = 0;
          end else begin
            burst_left = $urandom_range(0, 12);
            gap_left = $urandom_range(1, 5);
          end
        end else begin
          s_tvalid_i <= 1'b0;
        end
      end

      if (steady) begin
        m_tready_i <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        m_tready_i <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 7);
        m_tready_i <= 1'b0;
      end else begin
        m_tready_i <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: check the motor word first, then predict from the accepted command
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    motor_word_t got, want, next_want;
    if (rst_ni) begin
      quiet_cycles++;
      if (m_tvalid_o && m_tready_i) begin
        quiet_cycles = 0;
        got = motor_word_t'(m_tdata_o[18:0]);
        if (motor_expected.size() == 0) begin
          report($sformatf("unexpected motor word %h", m_tdata_o));
        end else begin
          want = motor_expected.pop_front();
          if (got.dir_a !== want.dir_a)
            report($sformatf("word %0d dir_a %b, want %b", words_checked, got.dir_a, want.dir_a));
          if (got.dir_b !== want.dir_b)
            report($sformatf("word %0d dir_b %b, want %b", words_checked, got.dir_b, want.dir_b));
          if (got.duty !== want.duty)
            report($sformatf("word %0d duty %0d, want %0d", words_checked, got.duty, want.duty));
          if (got.preset !== want.preset)
            report($sformatf("word %0d preset %b, want %b", words_checked, got.preset,
                             want.preset));
          if (got.phase !== want.phase)
            report($sformatf("word %0d phase %0d, want %0d", words_checked, got.phase,
                             want.phase));
        end
        words_checked++;
      end
      if (s_tvalid_i && s_tready_o) begin
        quiet_cycles = 0;
        if (step_controller(word_on_bus, next_want)) motor_expected.push_back(next_want);
        bus_busy = 1'b0;
      end
      // nothing moving on either side for too long
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("indexed_position_pid_with_homing regression: fail");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  task automatic queue_word(logic [1:0] mode, logic [31:0] now, logic [15:0] enc,
                            logic [2:0] req);
    cmd_word_t w;
    w.mode = mode;
    w.now = now;
    w.enc = enc;
    w.req = req;
    pending_words.push_back(w);
  endtask

  // wait until every queued command is taken and every motor word is back
  task automatic drain();
    while (pending_words.size() != 0 || bus_busy || motor_expected.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      REG_KP_GAIN:   kp = val;
      REG_KI_PERIOD: ki = val;
      REG_KD_PERIOD: kd = val;
      REG_PWM_PER:   pwm_per = val[15:0];
      REG_SPACING:   spacing = val[12:0];
      REG_EDGE:      edge_at = val[12:0];
      REG_STALL_MS:  stall_len = val[15:0];
      default:       deadband = val[15:0];
    endcase
  endtask

  function automatic logic [31:0] reg_ceiling(cfg_reg_e idx);
    case (idx)
      REG_KP_GAIN, REG_KI_PERIOD, REG_KD_PERIOD: return 32'hffff_ffff;
      REG_SPACING, REG_EDGE:                     return 32'h1fff;
      default:                                   return 32'hffff;
    endcase
  endfunction

  // values that keep the loop in a useful range
  function automatic logic [31:0] typical_value(cfg_reg_e idx);
    case (idx)
      REG_KP_GAIN:   return $urandom_range(0, 200 << 16);
      REG_KI_PERIOD: return $urandom_range(0, 32'h1_0000);
      REG_KD_PERIOD: return $urandom_range(0, 100 << 16);
      REG_PWM_PER:   return $urandom_range(4, 4000);
      REG_SPACING:   return $urandom_range(1, 2000);
      REG_EDGE:      return $urandom_range(0, 8191);
      REG_STALL_MS:  return $urandom_range(5, 100);
      default:       return $urandom_range(0, 1000);
    endcase
  endfunction

  // first setting all zeros, second all ceilings, the rest a random mix
  task automatic load_settings(int seg);
    cfg_reg_e    idx;
    logic [31:0] val;
    int          pick;
    for (int i = 0; i < 8; i++) begin
      idx = cfg_reg_e'(i);
      pick = $urandom_range(0, 9);
      if (seg == 1) val = '0;
      else if (seg == 2) val = reg_ceiling(idx);
      else if (pick == 0) val = '0;
      else if (pick == 1) val = reg_ceiling(idx);
      else if (pick == 2) val = $urandom() & reg_ceiling(idx);
      else val = typical_value(idx);
      write_reg(idx, val);
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // start, moving ticks, standing ticks, position requests, usually a stop
  task automatic queue_homing_cycle(output int count);
    int          moves, holds, runs, pick;
    logic [31:0] hop;
    logic [2:0]  want_req;
    moves = $urandom_range(1, 5);
    holds = $urandom_range(2, 6);
    runs = $urandom_range(3, 25);
    hop = {16'b0, stall_len} / 3 + 1;
    // sometimes stand still too briefly to find the edge
    if ($urandom_range(0, 3) == 0) hop = $urandom_range(1, hop);
    want_req = 3'($urandom_range(0, 7));
    count = 1 + moves + holds + runs;

    clock_ms += $urandom_range(1, 50);
    queue_word(MODE_START, clock_ms, shaft, want_req);
    repeat (moves) begin
      clock_ms += $urandom_range(1, 20);
      shaft += 16'($urandom_range(1, 40));
      queue_word(MODE_TICK, clock_ms, shaft, 3'($urandom_range(0, 7)));
    end
    repeat (holds) begin
      clock_ms += hop;
      queue_word(MODE_TICK, clock_ms, shaft, want_req);
    end
    repeat (runs) begin
      pick = $urandom_range(0, 9);
      if (pick == 9) want_req = 3'($urandom_range(5, 7));
      else if (pick >= 5) want_req = 3'($urandom_range(0, 4));
      if ($urandom_range(0, 7) == 0) shaft = 16'($urandom());
      else shaft = 16'(index_target(want_req) + longint'($urandom_range(0, 400)) - 200);
      clock_ms += $urandom_range(1, 30);
      queue_word(MODE_TICK, clock_ms, shaft, want_req);
    end
    pick = $urandom_range(0, 3);
    if (pick <= 2) queue_word(MODE_STOP, clock_ms, shaft, want_req);
    if (pick == 2) begin
      repeat ($urandom_range(1, 3)) begin
        clock_ms += 10;
        queue_word(MODE_TICK, clock_ms, 16'($urandom()), 3'($urandom_range(0, 7)));
      end
    end
  endtask

  initial begin
    int budget, added;
    bit paused;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // directed: reset settings, idle handling, homing edge, each request
    queue_word(MODE_TICK,   32'd10,  16'h0000, REQ_MIDDLE);     // idle tick
    queue_word(MODE_UNUSED, 32'd20,  16'h7fff, REQ_SPARE_HI);   // ignored mode
    queue_word(MODE_STOP,   32'd30,  16'h0000, REQ_FAR_RIGHT);  // stop while idle
    queue_word(MODE_START,  32'd100, 16'h0000, REQ_FAR_RIGHT);
    queue_word(MODE_TICK,   32'd101, 16'h0000, REQ_FAR_RIGHT);  // same as reset encoder
    queue_word(MODE_TICK,   32'd150, 16'h0005, REQ_FAR_RIGHT);  // encoder moved
    queue_word(MODE_TICK,   32'd200, 16'h0005, REQ_FAR_RIGHT);  // not stalled long enough
    queue_word(MODE_TICK,   32'd221, 16'h0005, REQ_FAR_RIGHT);  // edge found
    queue_word(MODE_TICK,   32'd230, 16'd1990, REQ_SPARE_HI);   // request unchanged, ramp kept
    queue_word(MODE_TICK,   32'd240, 16'h7fff, REQ_FAR_RIGHT);
    queue_word(MODE_TICK,   32'd250, 16'h8000, REQ_RIGHT);
    queue_word(MODE_TICK,   32'd260, 16'h0000, REQ_MIDDLE);
    queue_word(MODE_TICK,   32'd270, 16'hfcd6, REQ_LEFT);
    queue_word(MODE_TICK,   32'd280, 16'hf9ac, REQ_FAR_LEFT);
    queue_word(MODE_TICK,   32'd290, 16'h0064, REQ_FAR_LEFT);   // repeat request
    queue_word(MODE_TICK,   32'd300, 16'h0000, REQ_SPARE_LO);
    queue_word(MODE_TICK,   32'd310, 16'h0000, REQ_SPARE_MD);
    queue_word(MODE_STOP,   32'd320, 16'h0000, REQ_MIDDLE);
    queue_word(MODE_TICK,   32'd330, 16'h0000, REQ_MIDDLE);     // idle again
    queue_word(MODE_START,  32'hffff_fff0, 16'h0007, REQ_MIDDLE);
    queue_word(MODE_TICK,   32'h0000_0010, 16'h0007, REQ_MIDDLE); // ramp wraps
    queue_word(MODE_TICK,   32'hffff_ffff, 16'hffff, REQ_MIDDLE);
    queue_word(MODE_STOP,   32'hffff_ffff, 16'hffff, REQ_MIDDLE);

    for (int seg = 1; seg <= SEGMENTS; seg++) begin
      drain();
      repeat (PIPE_SETTLE) @(posedge clk_i);
      load_settings(seg);
      steady = (seg % 3 == 0);
      clock_ms = $urandom();
      shaft = 16'($urandom());
      budget = 0;
      paused = 1'b0;
      while (budget < SEG_ITEMS) begin
        // halfway: hold the sender until the pipe is empty
        if (!paused && budget >= SEG_ITEMS / 2) begin
          drain();
          paused = 1'b1;
          steady = 1'b0;
        end
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 4))
            queue_word(2'($urandom_range(0, 3)), $urandom(), 16'($urandom()),
                       3'($urandom_range(0, 7)));
        end else begin
          queue_homing_cycle(added);
          budget += added;
        end
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("indexed_position_pid_with_homing regression: pass");
    end else begin
      $display("indexed_position_pid_with_homing regression: fail");
    end
    $finish;
  end

endmodule
